### src/i2cbm_pkg.sv
// Package for the I2C bit-level master: command codes, state types, helpers.
`default_nettype none
package i2cbm_pkg;

    typedef enum logic [2:0] {
        OP_START = 3'd0,
        OP_STOP  = 3'd1,
        OP_WRITE = 3'd2,
        OP_READ  = 3'd3,
        OP_SACK  = 3'd4,
        OP_RACK  = 3'd5
    } t_op;

    localparam logic [15:0] PHASE_TICKS_RST = 16'd10;
    localparam logic [15:0] TICK_MAX        = 16'hFFFF;

    // Bus state carried from one tick to the next.
    typedef struct packed {
        logic        scl;
        logic        sda;
        logic        active;
        t_op         cmd;
        logic [4:0]  phase;
        logic [15:0] ticks;
        logic [7:0]  tx_sh;
        logic [7:0]  rx_sh;
        logic        ack;
    } t_state;

    // One result transaction.
    typedef struct packed {
        logic       scl;
        logic       sda_out;
        logic       busy;
        logic       done;
        logic [7:0] rx_byte;
        logic       ack_seen;
    } t_result;

    localparam t_state STATE_RST = '{
        scl:    1'b1,
        sda:    1'b1,
        active: 1'b0,
        cmd:    OP_START,
        phase:  5'd0,
        ticks:  16'd0,
        tx_sh:  8'd0,
        rx_sh:  8'd0,
        ack:    1'b1
    };

    // Number of line phases per command.
    function automatic logic [4:0] seq_len(input t_op op);
        logic [4:0] len;
        case (op)
            OP_START: len = 5'd4;
            OP_STOP:  len = 5'd3;
            OP_WRITE: len = 5'd24;
            OP_READ:  len = 5'd25;
            OP_SACK:  len = 5'd3;
            OP_RACK:  len = 5'd4;
            default:  len = 5'd4;
        endcase
        return len;
    endfunction

    // p / 3 for p below 32: (p * 11) >> 5 is exact over that range.
    function automatic logic [3:0] div3(input logic [4:0] p);
        logic [8:0] prod;
        prod = 9'(p) * 9'd11;
        return prod[8:5];
    endfunction

endpackage
`default_nettype wire

### src/i2c_bit_level_master.sv
// Top level of the I2C bit-level master: state, config register, output skid.
//
// Usage:
//  - Input channel (i_in_valid / o_in_stall): one transaction per bit-timer
//    tick, carrying an optional command (start, stop, write byte, read byte,
//    send ack, receive ack) and the sampled SDA level.
//  - Output channel (o_out_valid / i_out_stall): one transaction per input
//    transaction, giving SCL/SDA drive levels, busy, done pulse, the read
//    shift register and the last sampled ack.
//  - Config: i_cfg_wr_en writes i_cfg_wr_data into phase_ticks (ticks each
//    line phase is held, 0 acts as 1). Write only with no transaction in
//    flight; a new value applies from the next tick, also mid-command.
//  - Each result is registered (skid reg if the output stalls). Throughput:
//    one transaction per cycle while o_in_stall is low, set by the single
//    next-state step between the state registers and the result reg.
//  - Commands arriving while busy, and codes 6 and 7, are ignored.
//  - Stall: a two-entry output buffer (result reg + skid reg) takes one more
//    input while the output stalls; after that o_in_stall stays high
//    until the result reg is taken and the skid result moves into it.
//  - Reset (synchronous, active low): lines idle high, block idle,
//    phase_ticks = 10, ack_seen = 1, output buffer empty.
`default_nettype none
module i2c_bit_level_master
    import i2cbm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_cmd_valid,
    input  logic [2:0]  i_operation,
    input  logic [7:0]  i_tx_byte,
    input  logic        i_ack_out,
    input  logic        i_sda_in,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_scl,
    output logic        o_sda_out,
    output logic        o_busy_res,
    output logic        o_done_res,
    output logic [7:0]  o_rx_byte,
    output logic        o_ack_seen
);

    logic [15:0] r_phase_ticks;
    t_state      r_state;
    t_state      w_step_state;
    logic        w_step_done;
    t_result     w_res;

    logic        r_out_vld, n_out_vld;
    logic        r_skid_vld, n_skid_vld;
    t_result     r_out, n_out;
    t_result     r_skid, n_skid;

    logic        w_accept;
    logic        w_out_take;

    assign o_in_stall = r_skid_vld;
    assign w_accept   = i_in_valid && !r_skid_vld;
    assign w_out_take = r_out_vld && !i_out_stall;

    i2cbm_step u_step (
        .i_state       (r_state),
        .i_cmd_valid   (i_cmd_valid),
        .i_operation   (i_operation),
        .i_tx_byte     (i_tx_byte),
        .i_ack_out     (i_ack_out),
        .i_sda_in      (i_sda_in),
        .i_phase_ticks (r_phase_ticks),
        .o_state       (w_step_state),
        .o_done        (w_step_done)
    );

    assign w_res = '{
        scl:      w_step_state.scl,
        sda_out:  w_step_state.sda,
        busy:     w_step_state.active,
        done:     w_step_done,
        rx_byte:  w_step_state.rx_sh,
        ack_seen: w_step_state.ack
    };

    // config register and bus state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_ticks <= PHASE_TICKS_RST;
            r_state       <= STATE_RST;
        end else begin
            if (i_cfg_wr_en) r_phase_ticks <= i_cfg_wr_data;
            if (w_accept)    r_state       <= w_step_state;
        end
    end

    // output buffer: result reg in front, skid reg behind it
    always_comb begin
        n_out_vld  = r_out_vld;
        n_skid_vld = r_skid_vld;
        n_out      = r_out;
        n_skid     = r_skid;
        if (w_accept) begin
            // skid is empty here
            if (!r_out_vld || w_out_take) begin
                n_out     = w_res;
                n_out_vld = 1'b1;
            end else begin
                n_skid     = w_res;
                n_skid_vld = 1'b1;
            end
        end else if (w_out_take) begin
            if (r_skid_vld) begin
                n_out      = r_skid;
                n_skid_vld = 1'b0;
            end else begin
                n_out_vld = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            r_out_vld  <= n_out_vld;
            r_skid_vld <= n_skid_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_out_valid = r_out_vld;
    assign o_scl       = r_out.scl;
    assign o_sda_out   = r_out.sda_out;
    assign o_busy_res  = r_out.busy;
    assign o_done_res  = r_out.done;
    assign o_rx_byte   = r_out.rx_byte;
    assign o_ack_seen  = r_out.ack_seen;

`ifndef SYNTH
    // done tick already reports idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_done_res |-> !o_busy_res)
        else $error("done with busy set");

    // skid holds data only behind a full result reg
    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid valid with empty output");

    // idle block keeps phase and tick counters cleared
    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_state.active |-> (r_state.phase == 5'd0) && (r_state.ticks == 16'd0))
        else $error("counters not cleared while idle");

    // phase never runs past the command length
    a_phase_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.active |-> r_state.phase < seq_len(r_state.cmd))
        else $error("phase index out of range");

    // state only moves on an accepted transaction
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_accept |=> $stable(r_state))
        else $error("state changed without a transaction");
`endif

endmodule
`default_nettype wire

### src/i2cbm_step.sv
// One-tick next-state logic of the I2C bit-level master.
`default_nettype none
module i2cbm_step
    import i2cbm_pkg::*;
(
    input  t_state      i_state,
    input  logic        i_cmd_valid,
    input  logic [2:0]  i_operation,
    input  logic [7:0]  i_tx_byte,
    input  logic        i_ack_out,
    input  logic        i_sda_in,
    input  logic [15:0] i_phase_ticks,
    output t_state      o_state,
    output logic        o_done
);

    always_comb begin
        t_state     s;
        logic [3:0] q;
        logic [4:0] r;
        logic [4:0] pm1;
        logic [3:0] qm1;
        logic [4:0] rm1;
        logic [15:0] tick_inc;
        logic [4:0] phase_inc;

        s         = i_state;
        o_done    = 1'b0;
        tick_inc  = 16'd0;
        phase_inc = 5'd0;

        // command launch, only when idle and the code is known
        if (!s.active && i_cmd_valid && (i_operation <= OP_RACK)) begin
            s.active = 1'b1;
            s.cmd    = t_op'(i_operation);
            s.phase  = 5'd0;
            s.ticks  = 16'd0;
            if (s.cmd == OP_WRITE) begin
                s.tx_sh = i_tx_byte;
            end else if (s.cmd == OP_SACK) begin
                s.tx_sh = {i_ack_out, 7'd0};
            end else if (s.cmd == OP_READ) begin
                s.rx_sh = 8'd0;
            end
        end

        q   = div3(s.phase);
        r   = s.phase - (5'(q) * 5'd3);
        pm1 = s.phase - 5'd1;
        qm1 = div3(pm1);
        rm1 = pm1 - (5'(qm1) * 5'd3);

        if (s.active) begin
            // line change or sample on the first tick of a phase
            if (s.ticks == 16'd0) begin
                unique case (s.cmd)
                    OP_START: begin
                        if (s.phase == 5'd0)      s.sda = 1'b1;
                        else if (s.phase == 5'd1) s.scl = 1'b1;
                        else if (s.phase == 5'd2) s.sda = 1'b0;
                        else                      s.scl = 1'b0;
                    end
                    OP_STOP: begin
                        if (s.phase == 5'd0)      s.sda = 1'b0;
                        else if (s.phase == 5'd1) s.scl = 1'b1;
                        else                      s.sda = 1'b1;
                    end
                    OP_WRITE: begin
                        if (r == 5'd0)      s.sda = s.tx_sh[3'd7 - q[2:0]];
                        else if (r == 5'd1) s.scl = 1'b1;
                        else                s.scl = 1'b0;
                    end
                    OP_READ: begin
                        if (s.phase == 5'd0)  s.sda = 1'b1;
                        else if (rm1 == 5'd0) s.scl = 1'b1;
                        else if (rm1 == 5'd1) s.rx_sh = {s.rx_sh[6:0], i_sda_in};
                        else                  s.scl = 1'b0;
                    end
                    OP_SACK: begin
                        if (s.phase == 5'd0)      s.sda = s.tx_sh[7];
                        else if (s.phase == 5'd1) s.scl = 1'b1;
                        else                      s.scl = 1'b0;
                    end
                    default: begin
                        if (s.phase == 5'd0)      s.sda = 1'b1;
                        else if (s.phase == 5'd1) s.scl = 1'b1;
                        else if (s.phase == 5'd2) s.ack = i_sda_in;
                        else                      s.scl = 1'b0;
                    end
                endcase
            end

            tick_inc = (s.ticks != TICK_MAX) ? s.ticks + 16'd1 : s.ticks;
            s.ticks  = tick_inc;
            if (tick_inc >= i_phase_ticks) begin
                phase_inc = s.phase + 5'd1;
                s.ticks   = 16'd0;
                s.phase   = phase_inc;
                if (phase_inc >= seq_len(s.cmd)) begin
                    s.active = 1'b0;
                    s.phase  = 5'd0;
                    o_done   = 1'b1;
                end
            end
        end

        o_state = s;
    end

endmodule
`default_nettype wire

### dv/tb_i2c_bit_level_master.sv
// Self-checking testbench for the I2C bit-level master, predicted tick by tick.
module tb_i2c_bit_level_master;
    import i2cbm_pkg::*;

    // Reserved operation codes: the block must ignore them.
    localparam logic [2:0] OP_RSVD6 = 3'd6;
    localparam logic [2:0] OP_RSVD7 = 3'd7;

    localparam int RAND_TICKS  = 936;
    localparam int SUB_PHASES  = 8;        // random part: 4 idle mixes x 2 settings
    localparam int CYCLE_LIMIT = 200000;
    localparam int REPORT_MAX  = 10;

    // Lines released, block idle, nothing read yet: the state right after reset.
    localparam t_result IDLE_LINES = '{scl: 1'b1, sda_out: 1'b1, busy: 1'b0, done: 1'b0,
                                       rx_byte: 8'h00, ack_seen: 1'b1};

    // One row of the directed plan: either a config write or a run of identical ticks.
    typedef struct {
        bit          is_cfg;
        logic [15:0] period;
        int          reps;
        logic        cv;
        logic [2:0]  op;
        logic [7:0]  txb;
        logic        ackb;
        logic        sda;
        bit          pinned;     // ticks checked against a typed-in result
        t_result     want;
    } t_plan_row;

    // ------------------------------------------------------------------
    // DUT hookup; every input starts at a known value
    // ------------------------------------------------------------------
    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [15:0] cfg_wr_data = 16'd0;
    logic        in_valid    = 1'b0;
    logic        in_stall;
    logic        cmd_valid   = 1'b0;
    logic [2:0]  operation   = 3'd0;
    logic [7:0]  tx_byte     = 8'd0;
    logic        ack_out     = 1'b0;
    logic        sda_in      = 1'b1;
    logic        out_valid;
    logic        out_stall   = 1'b0;
    logic        scl;
    logic        sda_out;
    logic        busy_res;
    logic        done_res;
    logic [7:0]  rx_byte;
    logic        ack_seen;

    // Pinned expectation travels with the payload so the monitor sees it on acceptance.
    bit          pin_check   = 1'b0;
    t_result     pin_result  = IDLE_LINES;

    int          idle_pct    = 0;
    int          stall_pct   = 0;
    int          cycle_count = 0;
    int          errors      = 0;
    int          ticks_taken = 0;
    int          cmds_taken  = 0;
    int          done_pulses = 0;
    int          cfg_writes  = 0;

    t_result     line_expect_q[$];

    i2c_bit_level_master dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_cmd_valid   (cmd_valid),
        .i_operation   (operation),
        .i_tx_byte     (tx_byte),
        .i_ack_out     (ack_out),
        .i_sda_in      (sda_in),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_scl         (scl),
        .o_sda_out     (sda_out),
        .o_busy_res    (busy_res),
        .o_done_res    (done_res),
        .o_rx_byte     (rx_byte),
        .o_ack_seen    (ack_seen)
    );

    always #2 clk = ~clk;

    // Hard stop in case the handshake hangs.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still owed",
                     cycle_count, line_expect_q.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Result-side backpressure, redrawn every cycle.
    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // ------------------------------------------------------------------
    // Bus predictor: its own copy of the line state and the phase timer
    // ------------------------------------------------------------------
    logic        bus_scl;
    logic        bus_sda;
    logic        bus_active;
    t_op         bus_cmd;
    logic [4:0]  bus_phase;
    logic [15:0] bus_ticks;
    logic [15:0] bus_period;
    logic [7:0]  bus_tx;
    logic [7:0]  bus_rx;
    logic        bus_ack;

    task automatic bus_reset();
        bus_scl    = 1'b1;
        bus_sda    = 1'b1;
        bus_active = 1'b0;
        bus_cmd    = OP_START;
        bus_phase  = 5'd0;
        bus_ticks  = 16'd0;
        bus_period = PHASE_TICKS_RST;
        bus_tx     = 8'd0;
        bus_rx     = 8'd0;
        bus_ack    = 1'b1;
    endtask

    function automatic int phases_of(t_op op);
        case (op)
            OP_START: return 4;
            OP_STOP:  return 3;
            OP_WRITE: return 24;
            OP_READ:  return 25;
            OP_SACK:  return 3;
            default:  return 4;
        endcase
    endfunction

    // Line change (or SDA sample) made on the first tick of a phase.
    task automatic bus_phase_entry(input logic sda_now);
        int p;
        int r;
        p = bus_phase;
        case (bus_cmd)
            OP_START: begin
                if (p == 0)      bus_sda = 1'b1;
                else if (p == 1) bus_scl = 1'b1;
                else if (p == 2) bus_sda = 1'b0;    // SDA falls with SCL high
                else             bus_scl = 1'b0;
            end
            OP_STOP: begin
                if (p == 0)      bus_sda = 1'b0;
                else if (p == 1) bus_scl = 1'b1;
                else             bus_sda = 1'b1;    // SDA rises with SCL high
            end
            OP_WRITE: begin
                // three phases per bit, MSB first
                r = p % 3;
                if (r == 0)      bus_sda = bus_tx[7 - ((p / 3) % 8)];
                else if (r == 1) bus_scl = 1'b1;
                else             bus_scl = 1'b0;
            end
            OP_READ: begin
                // release SDA once, then SCL high / sample / SCL low per bit
                if (p == 0) begin
                    bus_sda = 1'b1;
                end else begin
                    r = (p - 1) % 3;
                    if (r == 0)      bus_scl = 1'b1;
                    else if (r == 1) bus_rx  = {bus_rx[6:0], sda_now};
                    else             bus_scl = 1'b0;
                end
            end
            OP_SACK: begin
                if (p == 0)      bus_sda = bus_tx[7];
                else if (p == 1) bus_scl = 1'b1;
                else             bus_scl = 1'b0;
            end
            default: begin
                // receive ack
                if (p == 0)      bus_sda = 1'b1;
                else if (p == 1) bus_scl = 1'b1;
                else if (p == 2) bus_ack = sda_now;
                else             bus_scl = 1'b0;
            end
        endcase
    endtask

    // One timer tick: maybe take a command, advance the phase, report the lines.
    task automatic bus_tick(input logic cv, input logic [2:0] op, input logic [7:0] txb,
                            input logic ackb, input logic sda_now, output t_result res);
        logic done;
        done = 1'b0;
        // commands while busy, and the reserved codes, fall on the floor
        if (!bus_active && cv && op <= OP_RACK) begin
            bus_active = 1'b1;
            bus_cmd    = t_op'(op);
            bus_phase  = 5'd0;
            bus_ticks  = 16'd0;
            cmds_taken++;
            if (op == OP_WRITE)     bus_tx = txb;
            else if (op == OP_SACK) bus_tx = {ackb, 7'd0};   // ack level rides in bit 7
            else if (op == OP_READ) bus_rx = 8'd0;
        end
        if (bus_active) begin
            if (bus_ticks == 16'd0) bus_phase_entry(sda_now);
            if (bus_ticks != TICK_MAX) bus_ticks++;
            // a period of zero still holds one tick; a period lowered mid-phase
            // ends the phase as soon as the count has reached it
            if (bus_ticks >= bus_period) begin
                bus_ticks = 16'd0;
                bus_phase++;
                if (bus_phase >= phases_of(bus_cmd)) begin
                    bus_active = 1'b0;     // busy already low on the done tick
                    bus_phase  = 5'd0;
                    done       = 1'b1;
                end
            end
        end
        res = '{scl: bus_scl, sda_out: bus_sda, busy: bus_active, done: done,
                rx_byte: bus_rx, ack_seen: bus_ack};
    endtask

    // ------------------------------------------------------------------
    // Monitor: predict on input acceptance, check on output acceptance
    // ------------------------------------------------------------------
    always @(posedge clk) begin : monitor
        t_result got;
        t_result want;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                got = '{scl: scl, sda_out: sda_out, busy: busy_res, done: done_res,
                        rx_byte: rx_byte, ack_seen: ack_seen};
                if (line_expect_q.size() == 0) begin
                    errors++;
                    if (errors <= REPORT_MAX) begin
                        $write("unexpected result at cycle %0d: scl %b sda %b busy %b ",
                               cycle_count, got.scl, got.sda_out, got.busy);
                        $display("done %b rx %h ack %b",
                                 got.done, got.rx_byte, got.ack_seen);
                    end
                end else begin
                    want = line_expect_q.pop_front();
                    if (got.scl !== want.scl || got.sda_out !== want.sda_out ||
                        got.busy !== want.busy || got.done !== want.done ||
                        got.rx_byte !== want.rx_byte || got.ack_seen !== want.ack_seen) begin
                        errors++;
                        if (errors <= REPORT_MAX) begin
                            $write("mismatch at cycle %0d (exp/act): scl %b/%b sda %b/%b ",
                                   cycle_count, want.scl, got.scl,
                                   want.sda_out, got.sda_out);
                            $display("busy %b/%b done %b/%b rx %h/%h ack %b/%b",
                                     want.busy, got.busy, want.done, got.done,
                                     want.rx_byte, got.rx_byte,
                                     want.ack_seen, got.ack_seen);
                        end
                    end
                end
            end
            // config and ticks never share an edge, so order here is free
            if (cfg_wr_en)
                bus_period = cfg_wr_data;
            if (in_valid && !in_stall) begin
                bus_tick(cmd_valid, operation, tx_byte, ack_out, sda_in, want);
                if (pin_check)
                    want = pin_result;
                if (want.done)
                    done_pulses++;
                ticks_taken++;
                line_expect_q.push_back(want);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic t_plan_row tick_row(input int reps, input logic cv, input logic [2:0] op,
                                           input logic [7:0] txb, input logic ackb,
                                           input logic sda);
        t_plan_row r;
        r.is_cfg = 1'b0;
        r.period = 16'd0;
        r.reps   = reps;
        r.cv     = cv;
        r.op     = op;
        r.txb    = txb;
        r.ackb   = ackb;
        r.sda    = sda;
        r.pinned = 1'b0;
        r.want   = IDLE_LINES;
        return r;
    endfunction

    function automatic t_plan_row cfg_row(input logic [15:0] period);
        t_plan_row r;
        r        = tick_row(0, 1'b0, OP_START, 8'd0, 1'b0, 1'b1);
        r.is_cfg = 1'b1;
        r.period = period;
        return r;
    endfunction

    // Single tick that must leave the idle lines untouched.
    function automatic t_plan_row idle_row(input logic cv, input logic [2:0] op);
        t_plan_row r;
        r        = tick_row(1, cv, op, 8'hFF, 1'b1, 1'b0);
        r.pinned = 1'b1;
        return r;
    endfunction

    // Offer one tick, with random sender gaps, and hold it until it is taken.
    task automatic offer_tick(input t_plan_row r);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        cmd_valid  <= r.cv;
        operation  <= r.op;
        tx_byte    <= r.txb;
        ack_out    <= r.ackb;
        sda_in     <= r.sda;
        pin_check  <= r.pinned;
        pin_result <= r.want;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // Stop offering, let every owed result come back, then settle before returning.
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(negedge clk); while (line_expect_q.size() != 0);
        repeat (3) @(posedge clk);
    endtask

    // phase_ticks is only written with nothing in flight; the bus itself may be mid-command.
    task automatic load_period(input logic [15:0] period);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= period;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        cfg_writes++;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        t_plan_row plan[$];
        t_plan_row r;
        int        sub;
        int        pick;

        bus_reset();

        // Directed plan. Most command rows repeat for the whole command length with the
        // command held, so the extra copies also check that a busy master ignores them.
        plan.push_back(idle_row(1'b0, OP_START));                 // quiet tick after reset
        plan.push_back(idle_row(1'b1, OP_RSVD6));                 // reserved codes
        plan.push_back(idle_row(1'b1, OP_RSVD7));
        plan.push_back(cfg_row(16'd0));                           // zero acts as one tick
        plan.push_back(tick_row(4,  1'b1, OP_START, 8'h00, 1'b0, 1'b1));
        plan.push_back(tick_row(1,  1'b1, OP_WRITE, 8'hFF, 1'b0, 1'b0));
        plan.push_back(tick_row(23, 1'b1, OP_STOP,  8'h00, 1'b0, 1'b1)); // stop while busy
        plan.push_back(tick_row(24, 1'b1, OP_WRITE, 8'h00, 1'b1, 1'b1));
        plan.push_back(tick_row(4,  1'b1, OP_RACK,  8'h00, 1'b0, 1'b0)); // acked
        plan.push_back(tick_row(25, 1'b1, OP_READ,  8'h00, 1'b0, 1'b1)); // all ones
        plan.push_back(tick_row(3,  1'b1, OP_SACK,  8'h00, 1'b1, 1'b0)); // nack
        plan.push_back(tick_row(3,  1'b1, OP_SACK,  8'hFF, 1'b0, 1'b1)); // ack
        plan.push_back(tick_row(4,  1'b1, OP_RACK,  8'h00, 1'b0, 1'b1)); // not acked
        plan.push_back(tick_row(25, 1'b1, OP_READ,  8'hFF, 1'b1, 1'b0)); // all zeros
        plan.push_back(tick_row(3,  1'b1, OP_STOP,  8'h00, 1'b0, 1'b0));
        plan.push_back(cfg_row(16'd1));
        plan.push_back(tick_row(4,  1'b1, OP_START, 8'h00, 1'b0, 1'b1));
        plan.push_back(tick_row(24, 1'b1, OP_WRITE, 8'hA5, 1'b0, 1'b1));
        plan.push_back(cfg_row(16'd3));
        plan.push_back(tick_row(12, 1'b1, OP_RACK,  8'h00, 1'b0, 1'b0));
        plan.push_back(tick_row(9,  1'b1, OP_SACK,  8'h00, 1'b1, 1'b1));
        plan.push_back(cfg_row(16'hFFFF));                        // longest phase
        plan.push_back(tick_row(40, 1'b1, OP_STOP,  8'h00, 1'b0, 1'b1));
        plan.push_back(cfg_row(16'd2));                           // shortened mid-phase
        plan.push_back(tick_row(8,  1'b0, OP_START, 8'h00, 1'b0, 1'b1));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].is_cfg)
                load_period(plan[i].period);
            else
                repeat (plan[i].reps) offer_tick(plan[i]);
        end

        // Random part. Any command order is legal at bit level, so each tick carries a
        // random command a quarter of the time; most land while busy and are dropped,
        // the rest start right after a done pulse. Short periods keep commands cheap.
        for (sub = 0; sub < SUB_PHASES; sub++) begin
            case (sub / 2)
                0: begin idle_pct = 0;  stall_pct <= 0;  end
                1: begin idle_pct = 52; stall_pct <= 0;  end
                2: begin idle_pct = 0;  stall_pct <= 52; end
                default: begin idle_pct = 26; stall_pct <= 26; end
            endcase
            pick = $urandom_range(4);
            load_period((pick == 4) ? 16'($urandom_range(7, 4)) : 16'(pick));
            repeat (RAND_TICKS / SUB_PHASES) begin
                r = tick_row(1, ($urandom_range(3) == 0),
                             ($urandom_range(15) == 0) ? 3'($urandom_range(7, 6))
                                                       : 3'($urandom_range(5)),
                             8'($urandom), 1'($urandom), 1'($urandom));
                offer_tick(r);
            end
        end

        stall_pct <= 0;
        drain_results();
        repeat (5) @(posedge clk);

        $display("%0d ticks checked, %0d commands started, %0d done pulses, %0d period writes",
                 ticks_taken, cmds_taken, done_pulses, cfg_writes);
        $display("periods 0, 1, 3, 65535 and random short ones, under sender gaps and stalls");
        if (errors == 0 && line_expect_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

### sim.f
src/i2cbm_pkg.sv
src/i2cbm_step.sv
src/i2c_bit_level_master.sv
dv/tb_i2c_bit_level_master.sv
